// ===== rtl/gwps_pkg.sv =====
package gwps_pkg;

  localparam int unsigned LaneN  = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned DtW    = 17;
  localparam int unsigned RootW  = 34;
  localparam int unsigned SumW   = 66;
  localparam int unsigned D3W    = 102;
  localparam int unsigned RemW   = 95;
  localparam int unsigned QuoW   = 32;

  typedef struct packed {
    logic [LaneN-1:0][WordW-1:0] pos;
    logic [LaneN-1:0][WordW-1:0] vel;
    logic [DtW-1:0]              dt;
  } side_t;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0]            neg;
    logic [LaneN-1:0][WordW-1:0] mag;
    logic [SumW-1:0]             diff;
    logic [RootW-1:0]            root;
  } sqrt_t;

  typedef struct packed {
    side_t                      sb;
    logic [LaneN-1:0]           neg;
    logic [D3W-1:0]             d3;
    logic [LaneN-1:0][RemW-1:0] rem;
    logic [LaneN-1:0][QuoW-1:0] quo;
  } div_t;

endpackage

// ===== rtl/gwps_sqrt_cell.sv =====
module gwps_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  gwps_pkg::sqrt_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output gwps_pkg::sqrt_t data_o
);
  import gwps_pkg::*;

  localparam int unsigned TrialW = 2 * RootW + 1;

  logic              valid_q;
  sqrt_t             data_q, data_d;
  logic [TrialW-1:0] trial;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one root bit per cell, diff holds s - root^2
  always_comb begin
    data_d = data_i;
    trial  = (TrialW'(data_i.root) << (BIT + 1)) | (TrialW'(1) << (2 * BIT));
    if (trial <= TrialW'(data_i.diff)) begin
      data_d.diff      = data_i.diff - trial[SumW-1:0];
      data_d.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/gwps_div_cell.sv =====
module gwps_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  gwps_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output gwps_pkg::div_t data_o
);
  import gwps_pkg::*;

  localparam int unsigned ShW = D3W + QuoW - 1;

  logic           valid_q;
  div_t           data_q, data_d;
  logic [ShW-1:0] shifted;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one quotient bit per cell for each lane
  always_comb begin
    data_d  = data_i;
    shifted = ShW'(data_i.d3) << BIT;
    for (int l = 0; l < LaneN; l++) begin
      if (ShW'(data_i.rem[l]) >= shifted) begin
        data_d.rem[l]      = data_i.rem[l] - shifted[RemW-1:0];
        data_d.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/gravity_well_particle_step.sv =====
// Gravity well particle step.
// Input channel: in_valid_i with pos, vel (x, y, z), all Q16.16, and
// time_step, unsigned Q1.16; the item is taken at a rising edge with
// in_valid_i high and in_stall_o low. Output channel: out_valid_o with
// new position, new velocity and acceleration; taken when out_valid_o is
// high and out_stall_i low. One result per item, in order.
// Configuration: cfg_valid_i with cfg_index_i / cfg_data_i writes well_x,
// well_y, well_z, min_distance, inverse_mass (index 0..4); cfg_ready_o is
// always high, other indexes are ignored. Write only while no item is in
// flight.
// The datapath runs through 77 registers: 3 front stages, 34 square root
// cells (one root bit each), 3 stages for d^3 and the numerators, 32
// divider cells (one quotient bit each, three lanes) and 5 stages for the
// Euler update. Throughput is one item per cycle while out_stall_i is low.
// Every stage is an elastic register: when out_stall_i holds the output,
// items still move forward into empty stages, and in_stall_o rises only
// once the chain is full back to the input.
// Reset empties the pipeline and loads the register defaults (well at the
// origin, min_distance and inverse_mass 0.1).
module gravity_well_particle_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [16:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import gwps_pkg::*;

  localparam int unsigned StN   = 11;
  localparam int unsigned PW    = 63;
  localparam int unsigned HalfW = RootW;

  typedef enum logic [2:0] {
    REG_WELL_X   = 3'd0,
    REG_WELL_Y   = 3'd1,
    REG_WELL_Z   = 3'd2,
    REG_MIN_DIST = 3'd3,
    REG_INV_MASS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0]            neg;
    logic [LaneN-1:0][WordW-1:0] mag;
  } fr_t;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0]            neg;
    logic [LaneN-1:0][WordW-1:0] mag;
    logic [LaneN-1:0][63:0]      sq;
  } sq_t;

  typedef struct packed {
    side_t                    sb;
    logic [LaneN-1:0]         neg;
    logic [LaneN-1:0][PW-1:0] p;
    logic [RootW-1:0]         d;
    logic [2*RootW-1:0]       d2;
  } dd_t;

  typedef struct packed {
    side_t                    sb;
    logic [LaneN-1:0]         neg;
    logic [LaneN-1:0][PW-1:0] p;
    logic [2*RootW-1:0]       pl;
    logic [2*RootW-1:0]       ph;
  } pp_t;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0][WordW-1:0] acc;
    logic [LaneN-1:0][WordW-1:0] amag;
  } ac_t;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0][WordW-1:0] acc;
    logic [LaneN-1:0][WordW-1:0] dm;
  } dv_t;

  typedef struct packed {
    side_t                       sb;
    logic [LaneN-1:0][WordW-1:0] acc;
    logic [LaneN-1:0][WordW-1:0] nv;
    logic [LaneN-1:0][WordW-1:0] nvm;
  } nv_t;

  typedef struct packed {
    logic [LaneN-1:0][WordW-1:0] np;
    logic [LaneN-1:0][WordW-1:0] nv;
    logic [LaneN-1:0][WordW-1:0] acc;
  } res_t;

  function automatic logic [WordW-1:0] sat34(logic [33:0] v);
    logic [WordW-1:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = 32'h7fff_ffff;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [LaneN-1:0][WordW-1:0] well_q;
  logic [30:0]                 min_dist_q;
  logic [30:0]                 inv_mass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      well_q     <= '0;
      min_dist_q <= 31'd6554;
      inv_mass_q <= 31'd6554;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WELL_X:   well_q[0]  <= cfg_data_i;
        REG_WELL_Y:   well_q[1]  <= cfg_data_i;
        REG_WELL_Z:   well_q[2]  <= cfg_data_i;
        REG_MIN_DIST: min_dist_q <= cfg_data_i[30:0];
        REG_INV_MASS: inv_mass_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [StN-1:0] v_q, rdy, nrdy, vin, ld;

  logic [RootW:0] sq_v, sq_r;
  sqrt_t          sq_c [RootW+1];
  logic [QuoW:0]  dv_v, dv_r;
  div_t           dv_c [QuoW+1];

  // ready runs from the output back to the input
  always_comb begin
    for (int k = StN - 1; k >= 0; k--) begin
      nrdy[k] = (k == StN - 1) ? !out_stall_i : rdy[(k + 1) % StN];
      if (k == 2) nrdy[k] = sq_r[0];
      if (k == 5) nrdy[k] = dv_r[0];
      rdy[k] = !v_q[k] || nrdy[k];
    end
    for (int k = 0; k < StN; k++) begin
      vin[k] = (k == 0) ? in_valid_i : v_q[(k + StN - 1) % StN];
    end
    vin[3] = sq_v[RootW];
    vin[6] = dv_v[QuoW];
    for (int k = 0; k < StN; k++) begin
      ld[k] = rdy[k] && vin[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < StN; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[StN-1];

  // stage 0: difference to the well
  side_t in_sb;
  fr_t   fr_d, fr_q;
  logic [LaneN-1:0][32:0] rdiff;

  assign in_sb.pos = {pos_z_i, pos_y_i, pos_x_i};
  assign in_sb.vel = {vel_z_i, vel_y_i, vel_x_i};
  assign in_sb.dt  = time_step_i;

  always_comb begin
    fr_d.sb = in_sb;
    for (int l = 0; l < LaneN; l++) begin
      rdiff[l]    = {well_q[l][31], well_q[l]} - {in_sb.pos[l][31], in_sb.pos[l]};
      fr_d.neg[l] = rdiff[l][32];
      fr_d.mag[l] = rdiff[l][32] ? 32'(-rdiff[l]) : rdiff[l][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) fr_q <= fr_d;
  end

  // stage 1: squares
  sq_t sqs_d, sqs_q;

  always_comb begin
    sqs_d.sb  = fr_q.sb;
    sqs_d.neg = fr_q.neg;
    sqs_d.mag = fr_q.mag;
    for (int l = 0; l < LaneN; l++) begin
      sqs_d.sq[l] = 64'(fr_q.mag[l]) * 64'(fr_q.mag[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) sqs_q <= sqs_d;
  end

  // stage 2: sum of squares, root chain seed
  sqrt_t rt_d, rt_q;

  always_comb begin
    rt_d.sb   = sqs_q.sb;
    rt_d.neg  = sqs_q.neg;
    rt_d.mag  = sqs_q.mag;
    rt_d.diff = SumW'(sqs_q.sq[0]) + SumW'(sqs_q.sq[1]) + SumW'(sqs_q.sq[2]);
    rt_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) rt_q <= rt_d;
  end

  assign sq_c[0]     = rt_q;
  assign sq_v[0]     = v_q[2];
  assign sq_r[RootW] = rdy[3];

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    gwps_sqrt_cell #(
      .BIT(RootW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sq_v[j]),
      .ready_o(sq_r[j]),
      .data_i (sq_c[j]),
      .valid_o(sq_v[j+1]),
      .ready_i(sq_r[j+1]),
      .data_o (sq_c[j+1])
    );
  end

  // stage 3: clamp, d^2 and numerators
  dd_t              dd_d, dd_q;
  logic [30:0]      min_eff;
  logic [RootW-1:0] root_len;

  always_comb begin
    root_len = sq_c[RootW].root;
    min_eff  = (min_dist_q == '0) ? 31'd1 : min_dist_q;
    dd_d.sb  = sq_c[RootW].sb;
    dd_d.neg = sq_c[RootW].neg;
    dd_d.d   = (root_len > RootW'(min_eff)) ? root_len : RootW'(min_eff);
    dd_d.d2  = (2*RootW)'(dd_d.d) * (2*RootW)'(dd_d.d);
    for (int l = 0; l < LaneN; l++) begin
      dd_d.p[l] = PW'(sq_c[RootW].mag[l]) * PW'(inv_mass_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) dd_q <= dd_d;
  end

  // stage 4: d^3 partial products
  pp_t pp_d, pp_q;

  always_comb begin
    pp_d.sb  = dd_q.sb;
    pp_d.neg = dd_q.neg;
    pp_d.p   = dd_q.p;
    pp_d.pl  = (2*RootW)'(dd_q.d2[HalfW-1:0]) * (2*RootW)'(dd_q.d);
    pp_d.ph  = (2*RootW)'(dd_q.d2[2*HalfW-1:HalfW]) * (2*RootW)'(dd_q.d);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) pp_q <= pp_d;
  end

  // stage 5: d^3, divider chain seed
  div_t dvs_d, dvs_q;

  always_comb begin
    dvs_d.sb  = pp_q.sb;
    dvs_d.neg = pp_q.neg;
    dvs_d.d3  = D3W'(pp_q.pl) + (D3W'(pp_q.ph) << HalfW);
    dvs_d.quo = '0;
    for (int l = 0; l < LaneN; l++) begin
      dvs_d.rem[l] = {pp_q.p[l], 32'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) dvs_q <= dvs_d;
  end

  assign dv_c[0]    = dvs_q;
  assign dv_v[0]    = v_q[5];
  assign dv_r[QuoW] = rdy[6];

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    gwps_div_cell #(
      .BIT(QuoW - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv_v[j]),
      .ready_o(dv_r[j]),
      .data_i (dv_c[j]),
      .valid_o(dv_v[j+1]),
      .ready_i(dv_r[j+1]),
      .data_o (dv_c[j+1])
    );
  end

  // stage 6: signed, saturated acceleration
  ac_t             ac_d, ac_q;
  logic [QuoW-1:0] quo;

  always_comb begin
    ac_d.sb = dv_c[QuoW].sb;
    quo     = '0;
    for (int l = 0; l < LaneN; l++) begin
      quo = dv_c[QuoW].quo[l];
      if (dv_c[QuoW].neg[l]) begin
        ac_d.acc[l]  = quo[31] ? 32'h8000_0000 : 32'(-quo);
        ac_d.amag[l] = quo[31] ? 32'h8000_0000 : quo;
      end else begin
        ac_d.acc[l]  = quo[31] ? 32'h7fff_ffff : quo;
        ac_d.amag[l] = quo[31] ? 32'h7fff_ffff : quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) ac_q <= ac_d;
  end

  // stage 7: a * dt
  dv_t dvm_d, dvm_q;

  always_comb begin
    dvm_d.sb  = ac_q.sb;
    dvm_d.acc = ac_q.acc;
    for (int l = 0; l < LaneN; l++) begin
      dvm_d.dm[l] = 32'((48'(ac_q.amag[l]) * 48'(ac_q.sb.dt)) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) dvm_q <= dvm_d;
  end

  // stage 8: new velocity
  nv_t               nv_d, nv_q;
  logic [LaneN-1:0][33:0] vsum;

  always_comb begin
    nv_d.sb  = dvm_q.sb;
    nv_d.acc = dvm_q.acc;
    for (int l = 0; l < LaneN; l++) begin
      vsum[l] = {{2{dvm_q.sb.vel[l][31]}}, dvm_q.sb.vel[l]}
              + (dvm_q.acc[l][31] ? 34'(-{2'b00, dvm_q.dm[l]}) : {2'b00, dvm_q.dm[l]});
      nv_d.nv[l]  = sat34(vsum[l]);
      nv_d.nvm[l] = nv_d.nv[l][31] ? 32'(-nv_d.nv[l]) : nv_d.nv[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[8]) nv_q <= nv_d;
  end

  // stage 9: new_vel * dt
  nv_t dp_d, dp_q;

  always_comb begin
    dp_d = nv_q;
    for (int l = 0; l < LaneN; l++) begin
      dp_d.nvm[l] = 32'((48'(nv_q.nvm[l]) * 48'(nv_q.sb.dt)) >> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[9]) dp_q <= dp_d;
  end

  // stage 10: new position, output register
  res_t              res_d, res_q;
  logic [LaneN-1:0][33:0] psum;

  always_comb begin
    res_d.nv  = dp_q.nv;
    res_d.acc = dp_q.acc;
    for (int l = 0; l < LaneN; l++) begin
      psum[l] = {{2{dp_q.sb.pos[l][31]}}, dp_q.sb.pos[l]}
              + (dp_q.nv[l][31] ? 34'(-{2'b00, dp_q.nvm[l]}) : {2'b00, dp_q.nvm[l]});
      res_d.np[l] = sat34(psum[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[10]) res_q <= res_d;
  end

  assign new_pos_x_o = res_q.np[0];
  assign new_pos_y_o = res_q.np[1];
  assign new_pos_z_o = res_q.np[2];
  assign new_vel_x_o = res_q.nv[0];
  assign new_vel_y_o = res_q.nv[1];
  assign new_vel_z_o = res_q.nv[2];
  assign accel_x_o   = res_q.acc[0];
  assign accel_y_o   = res_q.acc[1];
  assign accel_z_o   = res_q.acc[2];

endmodule
